// ===== rtl/bra_pkg.sv =====
// Package for the bitmap run allocator: widths, command codes, FSM states.
// Used by bra_engine and bitmap_run_allocator.
package bra_pkg;
	localparam int unsigned MapBitsDefault = 1024;
	localparam int unsigned WordBits = 32;
	localparam int unsigned CmdW = 3;
	localparam int unsigned IdxW = 10;
	localparam int unsigned LenW = 11;
	localparam int unsigned TotW = 11;
	localparam int unsigned TotReset = 1024;

	typedef enum logic [CmdW-1:0] {
		CMD_SET = 3'd0,
		CMD_CLR = 3'd1,
		CMD_TEST = 3'd2,
		CMD_ALLOC = 3'd3,
		CMD_FREE = 3'd4,
		CMD_ONE = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SCAN,
		ST_MARK,
		ST_RMW,
		ST_DONE
	} state_t;
endpackage

// ===== rtl/bra_ram.sv =====
// Generic single-port-write, single-read synchronous RAM, registered read.
// No dependencies.
module bra_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/bra_engine.sv =====
// Command sequencer: clears the map, scans words, read-modify-writes runs.
// Depends on bra_pkg and bra_ram.
module bra_engine #(
	parameter int unsigned MAP_BITS = bra_pkg::MapBitsDefault
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [bra_pkg::CmdW-1:0] cmd,
	input  logic [bra_pkg::IdxW-1:0] idx,
	input  logic [bra_pkg::LenW-1:0] len,
	input  logic [bra_pkg::TotW-1:0] tot,
	output logic                     busy,
	output logic                     done,
	output logic                     res_status,
	output logic [bra_pkg::IdxW-1:0] res_pos,
	output logic                     res_bit
);
	localparam int unsigned WB = bra_pkg::WordBits;
	localparam int unsigned NW = (MAP_BITS + WB - 1) / WB;
	localparam int unsigned AW = (NW > 1) ? $clog2(NW) : 1;
	localparam int unsigned BW = $clog2(WB);
	localparam int unsigned CntW = $clog2(MAP_BITS + 1);
	localparam int unsigned PW = ((CntW > bra_pkg::LenW) ? CntW : bra_pkg::LenW) + 1;
	localparam int unsigned MapB = MAP_BITS;

	bra_pkg::state_t st_q, st_d;
	logic [AW-1:0] waddr_q, raddr_q;
	logic          rvalid_q;
	logic [PW-1:0] lim_q, pos_q, run_q, start_q, len_q, end_q;
	logic [bra_pkg::CmdW-1:0] cmd_q;
	logic          stat_q, bit_q, setval_q;

	logic          we;
	logic [AW-1:0] wa, ra;
	logic [WB-1:0] wd, rd;
	logic [AW-1:0] first_w;

	bra_ram #(.WIDTH(WB), .DEPTH(1 << AW)) u_ram (
		.clk(clk), .we(we), .waddr(wa), .wdata(wd), .raddr(ra), .rdata(rd)
	);

	// run scan through one word; bits at or past the limit count as used
	logic [PW-1:0] run_n, start_n, base, seg;
	logic          found_n, seen_one;
	logic [BW-1:0] last_one;
	always_comb begin
		run_n = run_q;
		start_n = start_q;
		found_n = 1'b0;
		seen_one = 1'b0;
		last_one = '0;
		seg = '0;
		base = PW'(waddr_q) << BW;
		for (int b = 0; b < WB; b++) begin
			if (rd[b] || (base + PW'(b)) >= lim_q) begin
				seen_one = 1'b1;
				last_one = BW'(b);
			end else begin
				// zeros ending at bit b: since the last used bit, or carried in
				seg = seen_one ? (PW'(b) - PW'(last_one)) : (run_q + PW'(b) + 1'b1);
				if (!found_n && seg >= len_q) begin
					found_n = 1'b1;
					start_n = base + PW'(b) + 1'b1 - len_q;
				end
			end
		end
		if (seen_one) run_n = PW'(WB - 1) - PW'(last_one);
		else run_n = run_q + PW'(WB);
	end

	// mask of word bits in [start_q, end_q)
	logic [WB-1:0] mask;
	always_comb begin
		for (int b = 0; b < WB; b++) begin
			mask[b] = ((base + PW'(b)) >= start_q) && ((base + PW'(b)) < end_q);
		end
	end

	// allocations scan from word 0, the rest start at the word holding idx
	assign first_w = (cmd == bra_pkg::CMD_ALLOC || cmd == bra_pkg::CMD_ONE) ? '0 :
		AW'(PW'(idx) >> BW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= bra_pkg::ST_CLEAR;
			waddr_q <= '0;
			raddr_q <= '0;
			rvalid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			unique case (st_q)
				bra_pkg::ST_CLEAR: waddr_q <= waddr_q + 1'b1;
				bra_pkg::ST_IDLE: begin
					rvalid_q <= 1'b0;
					if (start) begin
						waddr_q <= first_w;
						raddr_q <= first_w;
					end
				end
				bra_pkg::ST_SCAN, bra_pkg::ST_MARK, bra_pkg::ST_RMW: begin
					rvalid_q <= 1'b1;
					if (rvalid_q) begin
						if (st_q == bra_pkg::ST_SCAN && found_n) begin
							// mark pass restarts at the run's first word
							waddr_q <= AW'(start_n >> BW);
							raddr_q <= AW'(start_n >> BW);
							rvalid_q <= 1'b0;
						end else begin
							waddr_q <= waddr_q + 1'b1;
							raddr_q <= raddr_q + 1'b1;
						end
					end
				end
				default: rvalid_q <= 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == bra_pkg::ST_IDLE && start) begin
			cmd_q <= cmd;
			run_q <= '0;
			bit_q <= 1'b0;
			stat_q <= 1'b0;
			pos_q <= '0;
			lim_q <= (PW'(tot) > PW'(MapB)) ? PW'(MapB) : PW'(tot);
			len_q <= (cmd == bra_pkg::CMD_ONE) ? PW'(1) : PW'(len);
			start_q <= PW'(idx);
			end_q <= PW'(idx) + PW'(len);
			setval_q <= (cmd == bra_pkg::CMD_SET);
			if (cmd == bra_pkg::CMD_SET || cmd == bra_pkg::CMD_CLR
			    || cmd == bra_pkg::CMD_TEST)
				end_q <= PW'(idx) + 1'b1;
		end else if (rvalid_q && st_q == bra_pkg::ST_SCAN) begin
			run_q <= run_n;
			if (found_n) begin
				start_q <= start_n;
				pos_q <= start_n;
				end_q <= start_n + len_q;
			end
		end else if (rvalid_q && st_q == bra_pkg::ST_RMW && cmd_q == bra_pkg::CMD_TEST) begin
			if ((|mask)) bit_q <= |(rd & mask);
		end
		if (st_q == bra_pkg::ST_SCAN && rvalid_q && !found_n
		    && ((PW'(waddr_q) + 1'b1) << BW) >= lim_q)
			stat_q <= 1'b1;
		if (st_q == bra_pkg::ST_IDLE && start) begin
			if ((cmd == bra_pkg::CMD_ALLOC && (len == '0 || PW'(len) > ((PW'(tot) >
			    PW'(MapB)) ? PW'(MapB) : PW'(tot)))) || (cmd == bra_pkg::CMD_ONE
			    && tot == '0) || (cmd == bra_pkg::CMD_FREE && len == '0)
			    || cmd > bra_pkg::CMD_ONE)
				stat_q <= 1'b1;
		end
	end

	logic bad_start;
	assign bad_start = (cmd == bra_pkg::CMD_ALLOC && (len == '0 || PW'(len) >
		((PW'(tot) > PW'(MapB)) ? PW'(MapB) : PW'(tot)))) ||
		(cmd == bra_pkg::CMD_ONE && tot == '0) ||
		(cmd == bra_pkg::CMD_FREE && len == '0) || cmd > bra_pkg::CMD_ONE ||
		((cmd == bra_pkg::CMD_SET || cmd == bra_pkg::CMD_CLR ||
		cmd == bra_pkg::CMD_TEST || cmd == bra_pkg::CMD_FREE) && PW'(idx) >= PW'(MapB));

	logic last_w;
	assign last_w = waddr_q == AW'(NW - 1);

	always_comb begin
		st_d = st_q;
		we = 1'b0;
		wa = waddr_q;
		wd = '0;
		ra = raddr_q;
		unique case (st_q)
			bra_pkg::ST_CLEAR: begin
				we = 1'b1;
				if (last_w) st_d = bra_pkg::ST_IDLE;
			end
			bra_pkg::ST_IDLE: begin
				ra = '0;
				if (start) begin
					if (bad_start) st_d = bra_pkg::ST_DONE;
					else if (cmd == bra_pkg::CMD_ALLOC || cmd == bra_pkg::CMD_ONE)
						st_d = bra_pkg::ST_SCAN;
					else st_d = bra_pkg::ST_RMW;
				end
			end
			bra_pkg::ST_SCAN: begin
				if (rvalid_q) begin
					ra = raddr_q + 1'b1;
					if (found_n) st_d = bra_pkg::ST_MARK;
					else if (((PW'(waddr_q) + 1'b1) << BW) >= lim_q)
						st_d = bra_pkg::ST_DONE;
				end
			end
			bra_pkg::ST_MARK, bra_pkg::ST_RMW: begin
				if (rvalid_q) begin
					ra = raddr_q + 1'b1;
					if (cmd_q != bra_pkg::CMD_TEST) begin
						we = 1'b1;
						wd = ((cmd_q == bra_pkg::CMD_ALLOC || cmd_q == bra_pkg::CMD_ONE
							|| setval_q)) ? (rd | mask) : (rd & ~mask);
					end
					if (last_w || ((PW'(waddr_q) + 1'b1) << BW) >= end_q)
						st_d = bra_pkg::ST_DONE;
				end
			end
			bra_pkg::ST_DONE: st_d = bra_pkg::ST_IDLE;
			default: st_d = bra_pkg::ST_IDLE;
		endcase
	end

	// MARK restarts at the run's first word; bits outside the mask are written back unchanged
	assign busy = st_q != bra_pkg::ST_IDLE;
	assign done = st_q == bra_pkg::ST_DONE;
	assign res_status = stat_q;
	assign res_pos = stat_q ? '0 : pos_q[bra_pkg::IdxW-1:0];
	assign res_bit = bit_q;
endmodule

// ===== rtl/bitmap_run_allocator.sv =====
// Top level of the bitmap run allocator: handshakes, config register, result register.
// Depends on bra_pkg and bra_engine.
//
// channel | dir | signals                              | transfer when
// in      | in  | in_valid, command, index, length     | in_valid && !in_stall
// out     | out | out_valid, status, position, bit_value | out_valid && !out_stall
// cfg     | in  | cfg_we, cfg_wdata                    | cfg_we
//
// Set/clear/free read-modify-write, and test reads, the words touched from the word holding index;
// allocations scan one 32-bit word per cycle from word 0, then sweep the run's words
// again to mark them. A rejected command goes straight to the done state.
// Words are read through the single memory read port, one at a time.
// After reset a clearing pass zeroes every map word with in_stall high.
// One item at a time; a result waiting on out_stall blocks the next item.
module bitmap_run_allocator #(
	parameter int unsigned MAP_BITS = bra_pkg::MapBitsDefault
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [bra_pkg::CmdW-1:0] command,
	input  logic [bra_pkg::IdxW-1:0] index,
	input  logic [bra_pkg::LenW-1:0] length,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     status,
	output logic [bra_pkg::IdxW-1:0] position,
	output logic                     bit_value,
	input  logic                     cfg_we,
	input  logic [bra_pkg::TotW-1:0] cfg_wdata
);
	logic [bra_pkg::TotW-1:0] tot_q;
	logic busy, done, r_st, r_bit, start;
	logic [bra_pkg::IdxW-1:0] r_pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tot_q <= bra_pkg::TotW'(bra_pkg::TotReset);
		else if (cfg_we) tot_q <= cfg_wdata;
	end

	assign in_stall = busy || out_valid;
	assign start = in_valid && !in_stall;

	bra_engine #(.MAP_BITS(MAP_BITS)) u_eng (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(command), .idx(index),
		.len(length), .tot(tot_q), .busy(busy), .done(done),
		.res_status(r_st), .res_pos(r_pos), .res_bit(r_bit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (done) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			status <= r_st;
			position <= r_pos;
			bit_value <= r_bit;
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> in_stall) else $error("accept while busy");
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("double result");
	a_fail_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status) |-> position == '0) else $error("pos on failure");
endmodule
